FILE: design/kne_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kne_pkg
// Shared types, codes and widths for the keypad numeric entry block.
// ----------------------------------------------------------------------------
package kne_pkg;

    // field widths
    localparam int unsigned MODE_W   = 2;
    localparam int unsigned KEY_W    = 4;
    localparam int unsigned KIND_W   = 4;
    localparam int unsigned VALUE_W  = 10;
    localparam int unsigned POS_W    = 8;
    localparam int unsigned IDLE_W   = 16;
    localparam int unsigned RES_W    = 7;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // stream word widths
    localparam int unsigned IN_TDATA_W  = 8;
    localparam int unsigned OUT_TDATA_W = 24;

    // register reset values
    localparam logic [IDLE_W-1:0]  IDLE_LIMIT_RST     = 16'd5000;
    localparam logic               METRIC_RST         = 1'b0;
    localparam logic [VALUE_W-1:0] SPEED_MAX_MET_RST  = 10'd200;
    localparam logic [VALUE_W-1:0] SPEED_MAX_IMP_RST  = 10'd120;
    localparam logic [RES_W-1:0]   RES_MAX_RST        = 7'd30;
    localparam logic [VALUE_W-1:0] INCLINE_MAX_RST    = 10'd150;

    // largest three digit value
    localparam logic [VALUE_W-1:0] VALUE_MAX = 10'd999;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_LIMIT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_METRIC_UNITS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_MAX_MET = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_MAX_IMP = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RES_MAX       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INCLINE_MAX   = 3'd5;

    // event codes
    typedef enum logic [MODE_W-1:0] {
        MODE_TICK  = 2'd0,
        MODE_DIGIT = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_TAKE  = 2'd3
    } t_mode;

    // setting being edited
    typedef enum logic [KIND_W-1:0] {
        KIND_SPEED      = 4'd0,
        KIND_RESISTANCE = 4'd1,
        KIND_INCLINE    = 4'd2,
        KIND_TIME       = 4'd3,
        KIND_WEIGHT     = 4'd4,
        KIND_AGE        = 4'd5,
        KIND_TIMEZONE   = 4'd6,
        KIND_LEVEL      = 4'd7,
        KIND_WATTS      = 4'd8,
        KIND_HEART_RATE = 4'd9
    } t_kind;

    // valid key codes
    localparam logic [KEY_W-1:0] KEY_MIN = 4'd1;
    localparam logic [KEY_W-1:0] KEY_MAX = 4'd10;

endpackage

FILE: design/keypad_numeric_entry_timeout.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypad_numeric_entry_timeout
// Keypad numeric entry with idle timeout: ticks, digit keys, clear and take
// events update the entry state, one result word per event.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake                      | payload
//  s_axis    | in        | s_axis_tvalid / s_axis_tready  | tdata key, kind; tuser mode
//  m_axis    | out       | m_axis_tvalid / m_axis_tready  | tdata value, digits, flags
//  cfg       | in        | i_cfg_valid / o_cfg_ready      | i_cfg_index, i_cfg_data
//
//  one word per cycle sustained while m_axis_tready stays high; an accepted
//  input word passes the input register, then the state update into the result register
//  the next state is combinational from the input register, so words follow back to back
//  reset is synchronous, active low, clears state and restores register defaults
//  a stalled result holds; the input register takes one more word, then
//  s_axis_tready drops until the result is taken
// ----------------------------------------------------------------------------
module keypad_numeric_entry_timeout
    import kne_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // input word
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [IN_TDATA_W-1:0]   s_axis_tdata,   // [3:0] key_code, [7:4] setting_kind
    input  logic [MODE_W-1:0]       s_axis_tuser,   // [1:0] mode
    // result word
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [OUT_TDATA_W-1:0]  m_axis_tdata,   // [9:0] entry_value,
                                                    // [17:10] digits_entered,
                                                    // [18] entry_active,
                                                    // [19] timeout_flag, [23:20] zero
    // configuration
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data
);

    // configuration registers
    logic [IDLE_W-1:0]  r_idle_limit;
    logic               r_metric;
    logic [VALUE_W-1:0] r_speed_max_met;
    logic [VALUE_W-1:0] r_speed_max_imp;
    logic [RES_W-1:0]   r_res_max;
    logic [VALUE_W-1:0] r_incline_max;

    // input stage
    logic               r_in_valid;
    t_mode              r_in_mode;
    logic [KEY_W-1:0]   r_in_key;
    logic [KIND_W-1:0]  r_in_kind;

    // entry state
    logic [IDLE_W-1:0]  r_idle, n_idle;
    logic [VALUE_W-1:0] r_val, n_val;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic               r_active, n_active;
    logic               r_await, n_await;
    logic               r_pend, n_pend;
    logic               n_flag_out;

    // result stage
    logic               r_out_valid;
    logic [VALUE_W-1:0] r_out_val;
    logic [POS_W-1:0]   r_out_pos;
    logic               r_out_active;
    logic               r_out_flag;

    logic               w_advance;
    logic               w_fire;
    logic               w_in_acc;

    // digit arithmetic
    logic [KEY_W-1:0]   w_d;
    logic [23:0]        w_q100_prod;
    logic [22:0]        w_q10_prod;
    logic [3:0]         w_q100;
    logic [6:0]         w_q10;
    logic [6:0]         w_m100;
    logic [3:0]         w_m10;
    logic [13:0]        w_t;
    logic [VALUE_W-1:0] w_w100;
    logic [6:0]         w_w10;
    logic [10:0]        w_sum;
    logic [VALUE_W-1:0] w_sum_mod;
    logic [VALUE_W-1:0] w_speed_lim;
    logic [VALUE_W-1:0] w_cap_lim;
    logic               w_key_ok;

    // handshake
    assign w_advance     = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || w_advance;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_fire        = r_in_valid && w_advance;
    assign o_cfg_ready   = 1'b1;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_limit    <= IDLE_LIMIT_RST;
            r_metric        <= METRIC_RST;
            r_speed_max_met <= SPEED_MAX_MET_RST;
            r_speed_max_imp <= SPEED_MAX_IMP_RST;
            r_res_max       <= RES_MAX_RST;
            r_incline_max   <= INCLINE_MAX_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_IDLE_LIMIT:    r_idle_limit    <= i_cfg_data;
                CFG_METRIC_UNITS:  r_metric        <= i_cfg_data[0];
                CFG_SPEED_MAX_MET: r_speed_max_met <= i_cfg_data[VALUE_W-1:0];
                CFG_SPEED_MAX_IMP: r_speed_max_imp <= i_cfg_data[VALUE_W-1:0];
                CFG_RES_MAX:       r_res_max       <= i_cfg_data[RES_W-1:0];
                CFG_INCLINE_MAX:   r_incline_max   <= i_cfg_data[VALUE_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in_mode <= t_mode'(s_axis_tuser);
            r_in_key  <= s_axis_tdata[KEY_W-1:0];
            r_in_kind <= s_axis_tdata[KEY_W+KIND_W-1:KEY_W];
        end
    end

    // decimal pieces of the current value: last digit and last two digits
    always_comb begin
        w_d         = r_in_key - KEY_MIN;
        w_q100_prod = 24'(r_val) * 24'd5243;
        w_q100      = w_q100_prod[22:19];
        w_m100      = 7'(r_val - 10'(w_q100) * 10'd100);
        w_q10_prod  = 23'(r_val) * 23'd6554;
        w_q10       = w_q10_prod[22:16];
        w_m10       = 4'(r_val - 10'(w_q10) * 10'd10);
        w_t         = 14'(r_val) * 14'd10 + 14'(w_d);
        w_w100      = 10'(w_m100) * 10'd10 + 10'(w_d);
        w_w10       = 7'(w_m10) * 7'd10 + 7'(w_d);
        w_sum       = 11'(r_val) + 11'(w_d);
        w_sum_mod   = (w_sum > 11'(VALUE_MAX)) ? 10'(w_sum - 11'd1000) : w_sum[VALUE_W-1:0];
        w_speed_lim = r_metric ? r_speed_max_met : r_speed_max_imp;
        w_cap_lim   = (r_in_kind == KIND_SPEED) ? w_speed_lim : r_incline_max;
        w_key_ok    = (r_in_key >= KEY_MIN) && (r_in_key <= KEY_MAX);
    end

    // next state for one event
    always_comb begin
        n_idle   = r_idle;
        n_val    = r_val;
        n_pos    = r_pos;
        n_active = r_active;
        n_await  = r_await;
        n_pend   = r_pend;
        case (r_in_mode)
            MODE_TICK: begin
                if (r_idle >= r_idle_limit) begin
                    n_idle   = '0;
                    n_val    = '0;
                    n_pos    = '0;
                    n_active = 1'b0;
                    if (r_await) begin
                        n_await = 1'b0;
                        n_pend  = 1'b1;
                    end
                end else begin
                    n_idle = r_idle + 16'd1;
                end
            end
            MODE_DIGIT: begin
                if (w_key_ok) begin
                    n_idle   = '0;
                    n_active = 1'b1;
                    n_await  = 1'b1;
                    n_pend   = 1'b0;
                    if (r_in_kind <= KIND_HEART_RATE) begin
                        n_pos = r_pos + 8'd1;
                        case (r_in_kind) inside
                            // three digit settings
                            KIND_SPEED, KIND_INCLINE, KIND_WEIGHT,
                            KIND_WATTS, KIND_HEART_RATE: begin
                                if (n_pos == 8'd1) begin
                                    n_val = 10'(w_d) * 10'd10;
                                end else if (n_pos == 8'd2) begin
                                    n_val = w_sum_mod;
                                end else if (n_pos == 8'd3) begin
                                    if (r_in_kind == KIND_SPEED &&
                                        w_t > 14'(w_speed_lim)) begin
                                        n_val = 10'(w_w10);
                                    end else if (w_t > 14'(VALUE_MAX)) begin
                                        n_val = w_w100;
                                    end else begin
                                        n_val = w_t[VALUE_W-1:0];
                                    end
                                end else if (n_pos == 8'd4) begin
                                    n_pos = 8'd3;
                                    if ((r_in_kind == KIND_SPEED ||
                                         r_in_kind == KIND_INCLINE) &&
                                        w_w100 > w_cap_lim) begin
                                        n_val = 10'(w_w10);
                                    end else begin
                                        n_val = w_w100;
                                    end
                                end
                            end
                            // two digit settings
                            KIND_TIME, KIND_AGE: begin
                                if (n_pos == 8'd1) begin
                                    n_val = 10'(w_d) * 10'd10;
                                end else if (n_pos == 8'd2) begin
                                    n_val = w_sum_mod;
                                end else if (n_pos == 8'd3) begin
                                    n_pos = 8'd2;
                                    n_val = 10'(w_w10);
                                end
                            end
                            // single digit first settings
                            default: begin
                                if (n_pos == 8'd1) begin
                                    n_val = 10'(w_d);
                                end else if (n_pos == 8'd2) begin
                                    n_pos = 8'd1;
                                    if (r_in_kind == KIND_RESISTANCE &&
                                        w_w10 > r_res_max) begin
                                        n_val = 10'(w_d);
                                    end else begin
                                        n_val = 10'(w_w10);
                                    end
                                end
                            end
                        endcase
                    end
                end
            end
            MODE_CLEAR: begin
                n_val    = '0;
                n_pos    = '0;
                n_active = 1'b0;
            end
            MODE_TAKE: begin
                n_pend = 1'b0;
            end
            default: ;
        endcase
    end

    // reported flag: value before a take clears it
    assign n_flag_out = (r_in_mode == MODE_TAKE) ? r_pend : n_pend;

    // entry state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle   <= '0;
            r_val    <= '0;
            r_pos    <= '0;
            r_active <= 1'b0;
            r_await  <= 1'b0;
            r_pend   <= 1'b0;
        end else if (w_fire) begin
            r_idle   <= n_idle;
            r_val    <= n_val;
            r_pos    <= n_pos;
            r_active <= n_active;
            r_await  <= n_await;
            r_pend   <= n_pend;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_val    <= n_val;
            r_out_pos    <= n_pos;
            r_out_active <= n_active;
            r_out_flag   <= n_flag_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out_flag, r_out_active, r_out_pos, r_out_val};

endmodule

FILE: design/kne_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kne_checker
// Port level checks for the keypad numeric entry block, bound to the top.
// ----------------------------------------------------------------------------
module kne_checker
    import kne_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    input  logic [OUT_TDATA_W-1:0]  m_axis_tdata
);

    // no result word straight after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // stalled result word holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // entry value stays within three digits
    a_value_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[9:0] <= VALUE_MAX)
        else $error("entry value above three digits");

    // no entry in progress means an empty entry
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[18] |-> m_axis_tdata[17:0] == 18'd0)
        else $error("inactive entry holds value or digits");

    // timeout flag only rises after the entry was abandoned
    a_flag_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[18] |-> !m_axis_tdata[19])
        else $error("timeout flag set while entry active");

endmodule

bind keypad_numeric_entry_timeout kne_checker u_kne_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
